FILE: hdl/pqp_pkg.sv
`timescale 1ns / 1ps
package pqp_pkg;

   localparam int CODE_BITS = 5;

   // item kinds
   localparam logic [1:0] KIND_PIXEL = 2'd0;
   localparam logic [1:0] KIND_WRITE = 2'd1;
   localparam logic [1:0] KIND_FLUSH = 2'd2;

   // quantizer modes
   localparam logic [1:0] MODE_RGB221  = 2'd0;
   localparam logic [1:0] MODE_GRAY    = 2'd1;
   localparam logic [1:0] MODE_NEAREST = 2'd2;
   localparam logic [1:0] MODE_EXACT   = 2'd3;

   // register indexes (paddr[2])
   localparam logic REG_QUANT_MODE      = 1'b0;
   localparam logic REG_PALETTE_ENTRIES = 1'b1;

   localparam logic [1:0] MODE_RESET    = MODE_RGB221;
   localparam logic [5:0] ENTRIES_RESET = 6'd32;
   localparam logic [7:0] START_DIST    = 8'd255;

   // Q16 luma weights
   localparam logic [15:0] LUMA_R = 16'd19595;
   localparam logic [15:0] LUMA_G = 16'd38470;
   localparam logic [15:0] LUMA_B = 16'd7471;

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [4:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [7:0] packed_byte;
      logic       is_final;
   } rsp_type;

   typedef struct packed {
      logic [1:0]           kind;
      logic [7:0]           red;
      logic [7:0]           green;
      logic [7:0]           blue;
      logic [4:0]           entry_index;
      logic [CODE_BITS-1:0] code;
      logic [7:0]           best_dist;
      logic                 found;
   } chain_item_type;

   // x / 255 for x below 8160, by shift and add
   function automatic logic [4:0] div255(input logic [13:0] x);
      logic [14:0] t;
      t = {1'b0, x} + 15'd1 + 15'(x[13:8]);
      return t[12:8];
   endfunction

endpackage

FILE: hdl/pqp_front.sv
`timescale 1ns / 1ps
module pqp_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [1:0]              quant_mode,
   input  logic                    in_valid,
   input  pqp_pkg::req_type        in_data,
   output logic                    out_valid,
   output pqp_pkg::chain_item_type out_item
);
   import pqp_pkg::*;

   logic                 valid_a_ff, valid_a_in;
   req_type              item_a_ff, item_a_in;
   logic [CODE_BITS-1:0] rgb_code_a_ff, rgb_code_a_in;
   logic [22:0]          prod_r_ff, prod_r_in;
   logic [23:0]          prod_g_ff, prod_g_in;
   logic [20:0]          prod_b_ff, prod_b_in;
   logic                 valid_b_ff, valid_b_in;
   chain_item_type       item_b_ff, item_b_in;

   logic [4:0]  red_lvl, green_lvl, gray_code;
   logic [23:0] luma_sum;
   logic [7:0]  luma;

   // stage A: fixed rgb code and luma products
   always_comb begin
      red_lvl   = div255(14'({in_data.red, 1'b0}) + 14'(in_data.red) + 14'd127);
      green_lvl = div255(14'({in_data.green, 1'b0}) + 14'(in_data.green) + 14'd127);
      valid_a_in    = advance ? in_valid : valid_a_ff;
      item_a_in     = advance ? in_data : item_a_ff;
      rgb_code_a_in = advance ? {red_lvl[1:0], green_lvl[1:0], in_data.blue[7]}
                              : rgb_code_a_ff;
      prod_r_in = advance ? 23'(in_data.red) * 23'(LUMA_R) : prod_r_ff;
      prod_g_in = advance ? 24'(in_data.green) * 24'(LUMA_G) : prod_g_ff;
      prod_b_in = advance ? 21'(in_data.blue) * 21'(LUMA_B) : prod_b_ff;
   end

   // stage B: luma sum, gray code, item for the chain
   always_comb begin
      luma_sum  = 24'(prod_r_ff) + prod_g_ff + 24'(prod_b_ff);
      luma      = luma_sum[23:16];
      gray_code = div255(14'({luma, 5'b0}) - 14'(luma) + 14'd127);
      valid_b_in = advance ? valid_a_ff : valid_b_ff;
      item_b_in  = item_b_ff;
      if (advance) begin
         item_b_in.kind        = item_a_ff.kind;
         item_b_in.red         = item_a_ff.red;
         item_b_in.green       = item_a_ff.green;
         item_b_in.blue        = item_a_ff.blue;
         item_b_in.entry_index = item_a_ff.entry_index;
         item_b_in.best_dist   = START_DIST;
         item_b_in.found       = 1'b0;
         case (quant_mode)
            MODE_RGB221: item_b_in.code = rgb_code_a_ff;
            MODE_GRAY:   item_b_in.code = gray_code;
            default:     item_b_in.code = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_a_ff <= 1'b0;
         valid_b_ff <= 1'b0;
      end else begin
         valid_a_ff <= valid_a_in;
         valid_b_ff <= valid_b_in;
      end
   end

   always_ff @(posedge clock) begin
      item_a_ff     <= item_a_in;
      rgb_code_a_ff <= rgb_code_a_in;
      prod_r_ff     <= prod_r_in;
      prod_g_ff     <= prod_g_in;
      prod_b_ff     <= prod_b_in;
      item_b_ff     <= item_b_in;
   end

   assign out_valid = valid_b_ff;
   assign out_item  = item_b_ff;

endmodule

FILE: hdl/pqp_cell.sv
`timescale 1ns / 1ps
module pqp_cell #(
   parameter int CELL_INDEX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    advance,
   input  logic [1:0]              quant_mode,
   input  logic [5:0]              active_entries,
   input  logic                    in_valid,
   input  pqp_pkg::chain_item_type in_item,
   output logic                    out_valid,
   output pqp_pkg::chain_item_type out_item
);
   import pqp_pkg::*;

   logic [23:0]    entry_ff, entry_in;
   logic           valid_ff, valid_in;
   chain_item_type item_ff, item_in;

   logic [7:0] diff_r, diff_g, diff_b;
   logic [9:0] manhattan;
   logic       in_use, is_pixel;

   always_comb begin
      diff_r = (entry_ff[23:16] > in_item.red) ? entry_ff[23:16] - in_item.red
                                               : in_item.red - entry_ff[23:16];
      diff_g = (entry_ff[15:8] > in_item.green) ? entry_ff[15:8] - in_item.green
                                                : in_item.green - entry_ff[15:8];
      diff_b = (entry_ff[7:0] > in_item.blue) ? entry_ff[7:0] - in_item.blue
                                              : in_item.blue - entry_ff[7:0];
      manhattan = 10'(diff_r) + 10'(diff_g) + 10'(diff_b);
      in_use    = 6'(CELL_INDEX) < active_entries;
      is_pixel  = in_item.kind == KIND_PIXEL;

      entry_in = entry_ff;
      if (advance && in_valid && in_item.kind == KIND_WRITE &&
          in_item.entry_index == 5'(CELL_INDEX)) begin
         entry_in = {in_item.red, in_item.green, in_item.blue};
      end

      valid_in = advance ? in_valid : valid_ff;
      item_in  = item_ff;
      if (advance) begin
         item_in = in_item;
         if (is_pixel && in_use) begin
            // strict compare keeps the lowest index on equal distance
            if (quant_mode == MODE_NEAREST && manhattan < 10'(in_item.best_dist)) begin
               item_in.best_dist = manhattan[7:0];
               item_in.code      = CODE_BITS'(CELL_INDEX);
            end
            if (quant_mode == MODE_EXACT && !in_item.found &&
                entry_ff == {in_item.red, in_item.green, in_item.blue}) begin
               item_in.found = 1'b1;
               item_in.code  = CODE_BITS'(CELL_INDEX);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      item_ff  <= item_in;
   end

   assign out_valid = valid_ff;
   assign out_item  = item_ff;

endmodule

FILE: hdl/pqp_pack.sv
`timescale 1ns / 1ps
module pqp_pack (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    tail_valid,
   input  pqp_pkg::chain_item_type tail_item,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output pqp_pkg::rsp_type        rsp_data,
   output logic                    advance
);
   import pqp_pkg::*;

   logic [7:0] acc_ff, acc_in;
   logic [2:0] fill_ff, fill_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_type    rsp_data_ff, rsp_data_in;

   logic [12:0] merged;
   logic [3:0]  fill_sum;
   logic        tail_emit;

   always_comb begin
      merged   = 13'(acc_ff) | (13'(tail_item.code) << fill_ff);
      fill_sum = {1'b0, fill_ff} + 4'(CODE_BITS);
      tail_emit = tail_valid &&
                  ((tail_item.kind == KIND_PIXEL && fill_sum[3]) ||
                   (tail_item.kind == KIND_FLUSH && fill_ff != 3'd0));
      // the chain only waits when its tail item needs the output slot
      advance = !rsp_valid_ff || rsp_ready || !tail_emit;

      acc_in       = acc_ff;
      fill_in      = fill_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (advance && tail_valid) begin
         case (tail_item.kind)
            KIND_PIXEL: begin
               fill_in = fill_sum[2:0];
               if (fill_sum[3]) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.packed_byte = merged[7:0];
                  rsp_data_in.is_final = 1'b0;
                  acc_in               = 8'(merged[12:8]);
               end else begin
                  acc_in = merged[7:0];
               end
            end
            KIND_FLUSH: begin
               if (fill_ff != 3'd0) begin
                  rsp_valid_in            = 1'b1;
                  rsp_data_in.packed_byte = acc_ff;
                  rsp_data_in.is_final    = 1'b1;
                  acc_in                  = 8'd0;
                  fill_in                 = 3'd0;
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= 8'd0;
         fill_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: hdl/pixel_quantize_5bit_packer_top.sv
`timescale 1ns / 1ps
// Pixel quantizer and 5-bit code packer.
// req channel (valid/ready): one item per handshake, kind pixel, palette entry
// write or flush. rsp channel (valid/ready): one packed byte per handshake,
// is_final set on a flushed partial byte. APB port: quant_mode at 0x0,
// palette_entries at 0x4; write them only while no item is in flight.
// Items pass a two-stage front end (fixed codes, luma), then a row of
// PALETTE_DEPTH cells, each holding one palette entry and updating the best
// match as the item passes, then the packer with its output register.
// The front end, cell row and packer advance together. Throughput: one item per
// cycle, except while the row waits on a stalled receiver (see below).
// Palette writes travel the row in order with pixels, so a pixel sees exactly
// the writes accepted before it.
// Reset clears the pipeline, the bit accumulator and the registers
// (quant_mode 0, palette_entries 32); palette entries read undefined until
// written. When the receiver stalls, the row keeps moving until an item that
// emits a byte reaches the packer; then req_ready drops until the byte is taken.
module pixel_quantize_5bit_packer_top #(
   parameter int PALETTE_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  pqp_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output pqp_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [2:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import pqp_pkg::*;

   logic [1:0] quant_mode_ff, quant_mode_in;
   logic [5:0] entries_ff, entries_in;
   logic [5:0] active_entries;
   logic       csr_write;
   logic       advance;

   logic           chain_valid [0:PALETTE_DEPTH];
   chain_item_type chain_item  [0:PALETTE_DEPTH];

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite;

   always_comb begin
      quant_mode_in = quant_mode_ff;
      entries_in    = entries_ff;
      if (csr_write) begin
         unique case (paddr[2])
            REG_QUANT_MODE:      quant_mode_in = pwdata[1:0];
            REG_PALETTE_ENTRIES: entries_in    = pwdata[5:0];
            default: ;
         endcase
      end
      unique case (paddr[2])
         REG_QUANT_MODE:      prdata = {30'd0, quant_mode_ff};
         REG_PALETTE_ENTRIES: prdata = {26'd0, entries_ff};
         default:             prdata = 32'd0;
      endcase
      // saturate to the cells present
      active_entries = (entries_ff > 6'(PALETTE_DEPTH)) ? 6'(PALETTE_DEPTH) : entries_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         quant_mode_ff <= MODE_RESET;
         entries_ff    <= ENTRIES_RESET;
      end else begin
         quant_mode_ff <= quant_mode_in;
         entries_ff    <= entries_in;
      end
   end

   assign req_ready = advance;

   pqp_front u_front (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .quant_mode (quant_mode_ff),
      .in_valid   (req_valid),
      .in_data    (req_data),
      .out_valid  (chain_valid[0]),
      .out_item   (chain_item[0])
   );

   for (genvar i = 0; i < PALETTE_DEPTH; i++) begin : g_cell
      pqp_cell #(
         .CELL_INDEX (i)
      ) u_cell (
         .clock          (clock),
         .reset          (reset),
         .advance        (advance),
         .quant_mode     (quant_mode_ff),
         .active_entries (active_entries),
         .in_valid       (chain_valid[i]),
         .in_item        (chain_item[i]),
         .out_valid      (chain_valid[i+1]),
         .out_item       (chain_item[i+1])
      );
   end

   pqp_pack u_pack (
      .clock      (clock),
      .reset      (reset),
      .tail_valid (chain_valid[PALETTE_DEPTH]),
      .tail_item  (chain_item[PALETTE_DEPTH]),
      .rsp_ready  (rsp_ready),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .advance    (advance)
   );

endmodule

FILE: hdl/pqp_checker.sv
`timescale 1ns / 1ps
module pqp_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input pqp_pkg::rsp_type rsp_data,
   input logic             psel,
   input logic             penable,
   input logic             pwrite,
   input logic [2:0]       paddr,
   input logic [31:0]      pwdata,
   input logic [31:0]      prdata,
   input logic             pready
);
   import pqp_pkg::*;

   // a stalled byte holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("rsp item changed while stalled");

   // reset empties the output
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // a waiting request keeps req_valid high
   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |=> req_valid)
      else $error("req_valid dropped before accept");

   // a mode write reads back at once
   a_mode_readback: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready && paddr[2] == REG_QUANT_MODE
      |=> !(psel && !pwrite && paddr[2] == REG_QUANT_MODE) ||
          prdata[1:0] == $past(pwdata[1:0]))
      else $error("quant_mode readback mismatch");

   a_prdata_upper: assert property (@(posedge clock) disable iff (reset)
      prdata[31:6] == 26'd0)
      else $error("unused register bits set");

endmodule

bind pixel_quantize_5bit_packer_top pqp_checker u_pqp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .psel      (psel),
   .penable   (penable),
   .pwrite    (pwrite),
   .paddr     (paddr),
   .pwdata    (pwdata),
   .prdata    (prdata),
   .pready    (pready)
);

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
module tb;
   import pqp_pkg::*;

   // kind code that the block must ignore
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam int PALETTE_SLOTS = 32;
   localparam int DRAIN_CYCLES = PALETTE_SLOTS + 10;
   localparam logic [2:0] ADDR_QUANT_MODE = {REG_QUANT_MODE, 2'b00};
   localparam logic [2:0] ADDR_PALETTE_ENTRIES = {REG_PALETTE_ENTRIES, 2'b00};

   logic        clock;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   req_type     req_data = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b1;
   rsp_type     rsp_data;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [2:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   // quantizer and packer mirror
   logic [1:0]  model_mode = MODE_RESET;
   logic [5:0]  model_entries = ENTRIES_RESET;
   logic [23:0] palette_copy [PALETTE_SLOTS];
   logic [7:0]  acc_bits = '0;
   int          acc_fill = 0;
   rsp_type     expected_bytes [$];

   int          mismatch_count = 0;
   bit          sender_gaps_on = 1'b1;
   bit          sink_stalls_on = 1'b1;

   pixel_quantize_5bit_packer_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("CHECKS FAILED");
      $finish;
   end

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch at %0t: %s expected %0h got %0h", $realtime, what, want, got);
      end
   endtask

   function automatic int unsigned channel_gap(input logic [7:0] a, input logic [7:0] b);
      return (a > b) ? int'(a - b) : int'(b - a);
   endfunction

   function automatic logic [4:0] quantize_pixel(input logic [7:0] r, input logic [7:0] g,
                                                 input logic [7:0] b);
      int unsigned n, best, d, y, r2, g2, b1;
      logic [4:0] code;
      bit hit;
      code = '0;
      hit = 1'b0;
      n = (model_entries > PALETTE_SLOTS) ? PALETTE_SLOTS : model_entries;
      case (model_mode)
         MODE_RGB221: begin
            r2 = (6 * r + 255) / 510;
            g2 = (6 * g + 255) / 510;
            b1 = (2 * b + 255) / 510;
            code = 5'((r2 << 3) | (g2 << 1) | b1);
         end
         MODE_GRAY: begin
            y = (19595 * r + 38470 * g + 7471 * b) >> 16;
            code = 5'((62 * y + 255) / 510);
         end
         MODE_NEAREST: begin
            best = 255;
            for (int j = 0; j < n; j++) begin
               d = channel_gap(palette_copy[j][23:16], r) +
                   channel_gap(palette_copy[j][15:8], g) +
                   channel_gap(palette_copy[j][7:0], b);
               if (d < best) begin
                  best = d;
                  code = 5'(j);
               end
            end
         end
         default: begin
            // lowest matching slot wins
            for (int j = 0; j < n; j++) begin
               if (!hit && palette_copy[j] == {r, g, b}) begin
                  hit = 1'b1;
                  code = 5'(j);
               end
            end
         end
      endcase
      return code;
   endfunction

   task automatic predict_item(input req_type it);
      logic [15:0] acc;
      logic [4:0]  code;
      rsp_type     want;
      case (it.kind)
         KIND_PIXEL: begin
            code = quantize_pixel(it.red, it.green, it.blue);
            acc = {8'd0, acc_bits} | ({11'd0, code} << acc_fill);
            if (acc_fill + CODE_BITS >= 8) begin
               want.packed_byte = acc[7:0];
               want.is_final = 1'b0;
               expected_bytes = {expected_bytes, want};
               acc_bits = acc[15:8];
               acc_fill = acc_fill + CODE_BITS - 8;
            end else begin
               acc_bits = acc[7:0];
               acc_fill = acc_fill + CODE_BITS;
            end
         end
         KIND_WRITE: begin
            palette_copy[it.entry_index] = {it.red, it.green, it.blue};
         end
         KIND_FLUSH: begin
            if (acc_fill != 0) begin
               want.packed_byte = acc_bits;
               want.is_final = 1'b1;
               expected_bytes = {expected_bytes, want};
               acc_bits = '0;
               acc_fill = 0;
            end
         end
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_bytes.size() == 0) begin
            note_mismatch("byte with nothing pending", '0, 32'(rsp_data));
         end else begin
            want = expected_bytes.pop_front();
            if (rsp_data.packed_byte !== want.packed_byte)
               note_mismatch("packed_byte", 32'(want.packed_byte), 32'(rsp_data.packed_byte));
            if (rsp_data.is_final !== want.is_final)
               note_mismatch("is_final", 32'(want.is_final), 32'(rsp_data.is_final));
         end
      end
   end

   // receiver stalls in bursts
   initial begin
      forever begin
         @(posedge clock);
         if (sink_stalls_on && $urandom_range(0, 6) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clock);
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic req_type build_item(input logic [1:0] kind, input logic [7:0] r,
                                          input logic [7:0] g, input logic [7:0] b,
                                          input logic [4:0] slot);
      req_type it;
      it.kind = kind;
      it.red = r;
      it.green = g;
      it.blue = b;
      it.entry_index = slot;
      return it;
   endfunction

   // hold valid and payload until accepted, then advance the mirror
   task automatic send_item(input req_type it);
      req_valid <= 1'b1;
      req_data <= it;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_item(it);
   endtask

   task automatic send_pixel(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      send_item(build_item(KIND_PIXEL, r, g, b, 5'($urandom_range(0, 31))));
   endtask

   task automatic send_flush();
      send_item(build_item(KIND_FLUSH, '0, '0, '0, '0));
   endtask

   task automatic sender_pause();
      if (sender_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic [2:0] addr, input bit is_write,
                             input logic [31:0] value, output logic [31:0] readback);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= addr;
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      readback = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_config(input logic [1:0] mode, input logic [5:0] entries);
      logic [31:0] readback;
      drain_pipeline();
      csr_access(ADDR_QUANT_MODE, 1'b1, 32'(mode), readback);
      csr_access(ADDR_PALETTE_ENTRIES, 1'b1, 32'(entries), readback);
      model_mode = mode;
      model_entries = entries;
      csr_access(ADDR_QUANT_MODE, 1'b0, '0, readback);
      if (readback[1:0] !== mode)
         note_mismatch("quant_mode readback", 32'(mode), readback);
      csr_access(ADDR_PALETTE_ENTRIES, 1'b0, '0, readback);
      if (readback[5:0] !== entries)
         note_mismatch("palette_entries readback", 32'(entries), readback);
   endtask

   function automatic logic [7:0] random_channel();
      if ($urandom_range(0, 9) == 0) return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [7:0] jitter(input logic [7:0] c);
      int v;
      v = int'(c) + int'($urandom_range(0, 80)) - 40;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return 8'(v);
   endfunction

   // mostly pixels; in palette modes most pixels sit on or near an active entry
   function automatic req_type random_item();
      req_type     it;
      int          pick;
      int unsigned n;
      logic [23:0] base;
      it = build_item(KIND_PIXEL, random_channel(), random_channel(), random_channel(),
                      5'($urandom_range(0, 31)));
      pick = $urandom_range(0, 99);
      n = (model_entries > PALETTE_SLOTS) ? PALETTE_SLOTS : model_entries;
      if (pick >= 97) begin
         it.kind = KIND_UNUSED;
      end else if (pick >= 87) begin
         it.kind = KIND_FLUSH;
      end else if (pick >= 75) begin
         it.kind = KIND_WRITE;
      end else if ((model_mode == MODE_NEAREST || model_mode == MODE_EXACT) && n != 0 &&
                   $urandom_range(0, 9) < 6) begin
         base = palette_copy[$urandom_range(0, n - 1)];
         if (model_mode == MODE_NEAREST) begin
            it.red = jitter(base[23:16]);
            it.green = jitter(base[15:8]);
            it.blue = jitter(base[7:0]);
         end else begin
            {it.red, it.green, it.blue} = base;
            if ($urandom_range(0, 3) == 0) it.blue = it.blue ^ (8'd1 << $urandom_range(0, 7));
         end
      end
      return it;
   endfunction

   task automatic test_fixed_rgb();
      // reset settings: rgb221, rounding edges on each channel
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd43, 8'd42, 8'd128);
      send_pixel(8'd127, 8'd128, 8'd127);
      send_flush();
      send_flush();
      send_item(build_item(KIND_UNUSED, random_channel(), random_channel(), random_channel(),
                           5'($urandom_range(0, 31))));
   endtask

   task automatic test_gray();
      set_config(MODE_GRAY, ENTRIES_RESET);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_pixel(8'd255, 8'd255, 8'd255);
      send_pixel(8'd0, 8'd255, 8'd0);
      send_pixel(8'd17, 8'd200, 8'd90);
      send_pixel(8'd255, 8'd0, 8'd255);
      send_flush();
   endtask

   task automatic test_palette_search();
      send_item(build_item(KIND_WRITE, 8'd0, 8'd0, 8'd0, 5'd0));
      send_item(build_item(KIND_WRITE, 8'd255, 8'd255, 8'd255, 5'd1));
      send_item(build_item(KIND_WRITE, 8'd255, 8'd0, 8'd0, 5'd2));
      send_item(build_item(KIND_WRITE, 8'd10, 8'd20, 8'd30, 5'd3));
      set_config(MODE_NEAREST, 6'd4);
      send_pixel(8'd12, 8'd22, 8'd33);
      send_pixel(8'd250, 8'd250, 8'd250);
      // no entry within 255, fall back to slot zero
      send_pixel(8'd128, 8'd128, 8'd128);
      send_pixel(8'd255, 8'd5, 8'd0);
      set_config(MODE_EXACT, 6'd4);
      send_pixel(8'd10, 8'd20, 8'd30);
      send_pixel(8'd10, 8'd20, 8'd31);
      send_pixel(8'd255, 8'd255, 8'd255);
      // empty palette search
      set_config(MODE_EXACT, 6'd0);
      send_pixel(8'd0, 8'd0, 8'd0);
      send_flush();
   endtask

   task automatic test_palette_load();
      logic [23:0] color;
      for (int slot = 0; slot < PALETTE_SLOTS; slot++) begin
         color = {random_channel(), random_channel(), random_channel()};
         if (slot == 0) color = 24'h000000;
         if (slot == PALETTE_SLOTS - 1) color = 24'hFFFFFF;
         sender_pause();
         send_item(build_item(KIND_WRITE, color[23:16], color[15:8], color[7:0], 5'(slot)));
      end
   endtask

   task automatic run_random_phase(input logic [1:0] mode, input logic [5:0] entries,
                                   input int count);
      set_config(mode, entries);
      sender_gaps_on = ($urandom_range(0, 3) != 0);
      sink_stalls_on = ($urandom_range(0, 3) != 0);
      for (int i = 0; i < count; i++) begin
         sender_pause();
         send_item(random_item());
      end
   endtask

   task automatic test_random_settings();
      run_random_phase(MODE_NEAREST, 6'd32, 130);
      run_random_phase(MODE_EXACT, 6'd63, 130);
      run_random_phase(MODE_NEAREST, 6'd1, 130);
      run_random_phase(MODE_EXACT, 6'd0, 130);
      run_random_phase(MODE_RGB221, 6'd32, 130);
      run_random_phase(MODE_NEAREST, 6'd2, 130);
      run_random_phase(MODE_EXACT, 6'd17, 130);
      run_random_phase(MODE_GRAY, 6'd33, 130);
   endtask

   task automatic test_full_rate();
      set_config(MODE_NEAREST, 6'($urandom_range(0, 63)));
      sender_gaps_on = 1'b0;
      sink_stalls_on = 1'b0;
      for (int i = 0; i < 80; i++) send_item(random_item());
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_fixed_rgb();
      test_gray();
      test_palette_search();
      test_palette_load();
      test_random_settings();
      test_full_rate();
      drain_pipeline();
      if (mismatch_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/pqp_pkg.sv
hdl/pqp_front.sv
hdl/pqp_cell.sv
hdl/pqp_pack.sv
hdl/pixel_quantize_5bit_packer_top.sv
hdl/pqp_checker.sv
tb/sv/tb.sv
